// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros
// assertion macros for the character reference decoder
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLIES(label, clk, rstn, a, c) \
    label: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rstn, a, c) \
    label: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rstn, a, c)
`define ASSERT_NEXT(label, clk, rstn, a, c)
`endif
`endif

// ----- rtl/xcr_pkg.sv -----
// ----------------------------------------------------------------------------
// xcr_pkg
// types and constants shared by the character reference decoder
// ----------------------------------------------------------------------------
package xcr_pkg;
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_X     = 8'h78;
    localparam logic [7:0] CH_QUOT  = 8'h22;
    localparam logic [7:0] CH_APOS  = 8'h27;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [3:0] DIGIT_LIMIT = 4'd11;

    // command from the front end to the back end
    localparam logic [1:0] CMD_BYTE  = 2'd0;  // emit one byte
    localparam logic [1:0] CMD_UTF8  = 2'd1;  // emit code value as utf-8
    localparam logic [1:0] CMD_FLUSH = 2'd2;  // emit held text then byte

    typedef struct packed {
        logic [1:0]  cmd;
        logic [7:0]  data;
        logic [31:0] value;
        logic [6:0]  count;
        logic        eos;
    } xcr_cmd_t;

    function automatic logic [4:0] hex_digit(input logic [7:0] b, input logic hex);
        logic [4:0] d;
        d = 5'h10;
        if (b >= 8'h30 && b <= 8'h39) d = {1'b0, b[3:0]};
        else if (hex && b >= 8'h61 && b <= 8'h66) d = 5'(b - 8'h57);
        else if (hex && b >= 8'h41 && b <= 8'h46) d = 5'(b - 8'h37);
        return d;
    endfunction
endpackage

// ----- rtl/xml_char_reference_decoder.sv -----
// ----------------------------------------------------------------------------
// xml_char_reference_decoder
// decodes xml character references in a byte stream to utf-8
// ----------------------------------------------------------------------------
//  channel | direction | ports
//  s_      | in        | s_valid s_ready s_in_byte s_end_of_string
//  m_      | out       | m_valid m_ready m_out_byte m_run_last m_string_last
//
// held bytes are accepted one per cycle while the command slot is free; a
// transaction that emits bytes holds the input while the back end drains
// its command. replay of held text reads one ram entry per cycle unless
// m_ready stalls it. aresetn is synchronous; the held text ram needs no
// clearing. output stalls back up through the command slot to s_ready.
module xml_char_reference_decoder
    import xcr_pkg::*;
#(
    parameter int PENDING_DEPTH = 32
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_in_byte,
    input  logic       s_end_of_string,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_byte,
    output logic       m_run_last,
    output logic       m_string_last
);
    localparam int AW = $clog2(PENDING_DEPTH);
    logic           cmd_valid, cmd_ready, wr_en;
    xcr_cmd_t       cmd;
    logic [AW-1:0]  wr_addr, rd_addr;
    logic [7:0]     wr_data, rd_data;

    xcr_front #(.PENDING_DEPTH(PENDING_DEPTH)) u_front (
        .aclk, .aresetn, .s_valid, .s_ready, .s_in_byte, .s_end_of_string,
        .cmd_valid, .cmd_ready, .cmd, .wr_en, .wr_addr, .wr_data
    );
    xcr_ram #(.WIDTH(8), .DEPTH(PENDING_DEPTH)) u_ram (
        .aclk, .wr_en, .wr_addr, .wr_data, .rd_addr, .rd_data
    );
    xcr_back #(.PENDING_DEPTH(PENDING_DEPTH)) u_back (
        .aclk, .aresetn, .cmd_valid, .cmd_ready, .cmd, .rd_addr, .rd_data,
        .m_valid, .m_ready, .m_out_byte, .m_run_last, .m_string_last
    );
endmodule

// ----- rtl/xcr_ram.sv -----
// ----------------------------------------------------------------------------
// xcr_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
module xcr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) mem[wr_addr] <= wr_data;
        rd_data <= mem[rd_addr];
    end
endmodule

// ----- rtl/xcr_front.sv -----
// ----------------------------------------------------------------------------
// xcr_front
// scans input bytes, tracks reference state and issues commands
// ----------------------------------------------------------------------------
module xcr_front
    import xcr_pkg::*;
#(
    parameter int PENDING_DEPTH = 32
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [7:0]                       s_in_byte,
    input  logic                             s_end_of_string,
    output logic                             cmd_valid,
    input  logic                             cmd_ready,
    output xcr_cmd_t                         cmd,
    output logic                             wr_en,
    output logic [$clog2(PENDING_DEPTH)-1:0] wr_addr,
    output logic [7:0]                       wr_data
);
    localparam int AW = $clog2(PENDING_DEPTH);
    localparam logic [2:0] M_IDLE = 3'd0, M_AMP = 3'd1, M_HASH = 3'd2,
        M_DEC = 3'd3, M_HEX = 3'd4, M_NAME = 3'd5, M_PASS = 3'd6;

    logic [2:0]  mode_reg, mode_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic [3:0]  dig_reg, dig_next;
    logic [31:0] val_reg, val_next;
    logic        ovf_reg, ovf_next, end_reg, end_next;
    logic [31:0] name_reg, name_next;  // first four name bytes after '&'
    logic        acc, emit;
    logic [4:0]  d;
    logic [35:0] prod;
    logic [7:0]  b;
    logic        named_ok;
    logic [7:0]  named_ch;

    assign b = s_in_byte;
    assign s_ready = cmd_ready;
    assign acc = s_valid && s_ready;
    assign d = hex_digit(b, mode_reg == M_HEX);
    assign prod = (mode_reg == M_HEX) ? {val_reg, 4'h0}
                : 36'({val_reg, 3'b0}) + 36'({val_reg, 1'b0});

    always_comb begin
        named_ok = 1'b0;
        named_ch = CH_AMP;
        if (cnt_reg == 7'd5 && name_reg == 32'h71756f74) begin
            named_ok = 1'b1; named_ch = CH_QUOT;
        end else if (cnt_reg == 7'd5 && name_reg == 32'h61706f73) begin
            named_ok = 1'b1; named_ch = CH_APOS;
        end else if (cnt_reg == 7'd3 && name_reg[31:16] == 16'h6774) begin
            named_ok = 1'b1; named_ch = CH_GT;
        end else if (cnt_reg == 7'd3 && name_reg[31:16] == 16'h6c74) begin
            named_ok = 1'b1; named_ch = CH_LT;
        end else if (cnt_reg == 7'd4 && name_reg[31:8] == 24'h616d70) begin
            named_ok = 1'b1;
        end
    end

    always_comb begin
        mode_next = mode_reg; cnt_next = cnt_reg; dig_next = dig_reg;
        val_next = val_reg; ovf_next = ovf_reg; end_next = end_reg;
        name_next = name_reg;
        emit = 1'b0;
        cmd = '{cmd: CMD_BYTE, data: b, value: val_reg, count: cnt_reg,
                eos: s_end_of_string};
        wr_en = 1'b0;
        wr_addr = cnt_reg[AW-1:0];
        wr_data = b;
        if (acc) begin
            if (mode_reg == M_IDLE) begin
                if (b == CH_AMP && !s_end_of_string) begin
                    wr_en = 1'b1; wr_addr = '0;
                    cnt_next = 7'd1; mode_next = M_AMP; dig_next = '0;
                    val_next = '0; ovf_next = 1'b0; end_next = 1'b0;
                    name_next = '0;
                end else begin
                    emit = 1'b1;
                end
            end else if (mode_reg == M_PASS) begin
                emit = 1'b1;
                if (b == CH_SEMI) mode_next = M_IDLE;
            end else if (b == CH_SEMI) begin
                emit = 1'b1;
                mode_next = M_IDLE;
                cnt_next = '0;
                if ((mode_reg == M_DEC || mode_reg == M_HEX) && dig_reg != 4'd0
                    && dig_reg < DIGIT_LIMIT && !ovf_reg) begin
                    cmd.cmd = CMD_UTF8;
                end else if (mode_reg == M_NAME && named_ok) begin
                    cmd.data = named_ch;
                end else begin
                    cmd.cmd = CMD_FLUSH;
                end
            end else if (s_end_of_string || cnt_reg >= 7'(PENDING_DEPTH)) begin
                emit = 1'b1;
                cmd.cmd = CMD_FLUSH;
                mode_next = M_PASS;
                cnt_next = '0;
            end else begin
                wr_en = 1'b1;
                cnt_next = cnt_reg + 7'd1;
                if (cnt_reg >= 7'd1 && cnt_reg <= 7'd4)
                    name_next[8*(4-cnt_reg[2:0]) +: 8] = b;
                if (mode_reg == M_AMP) begin
                    mode_next = (b == CH_HASH) ? M_HASH : M_NAME;
                end else if (mode_reg == M_HASH && b == CH_X) begin
                    mode_next = M_HEX;
                end else if (mode_reg != M_NAME) begin
                    if (mode_reg == M_HASH) mode_next = M_DEC;
                    if (!end_reg && dig_reg < DIGIT_LIMIT) begin
                        if (d[4]) begin
                            end_next = 1'b1;
                        end else begin
                            dig_next = dig_reg + 4'd1;
                            // hash mode digit uses decimal since hex flag is off
                            val_next = 32'(prod + 36'(d[3:0]));
                            if (prod + 36'(d[3:0]) > 36'hFFFFFFFF) ovf_next = 1'b1;
                        end
                    end
                end
            end
            if (s_end_of_string) begin
                mode_next = M_IDLE; cnt_next = '0;
            end
        end
    end
    assign cmd_valid = emit;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= M_IDLE; cnt_reg <= '0; dig_reg <= '0; val_reg <= '0;
            ovf_reg <= 1'b0; end_reg <= 1'b0; name_reg <= '0;
        end else begin
            mode_reg <= mode_next; cnt_reg <= cnt_next; dig_reg <= dig_next;
            val_reg <= val_next; ovf_reg <= ovf_next; end_reg <= end_next;
            name_reg <= name_next;
        end
    end
endmodule

// ----- rtl/xcr_back.sv -----
// ----------------------------------------------------------------------------
// xcr_back
// command queue and byte emitter: utf-8 encode, held text replay
// ----------------------------------------------------------------------------
module xcr_back
    import xcr_pkg::*;
#(
    parameter int PENDING_DEPTH = 32
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cmd_valid,
    output logic                             cmd_ready,
    input  xcr_cmd_t                         cmd,
    output logic [$clog2(PENDING_DEPTH)-1:0] rd_addr,
    input  logic [7:0]                       rd_data,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [7:0]                       m_out_byte,
    output logic                             m_run_last,
    output logic                             m_string_last
);
    localparam int AW = $clog2(PENDING_DEPTH);

    // one-entry command slot; the front end stalls while it is busy
    logic        busy_reg, busy_next;
    xcr_cmd_t    c_reg, c_next;
    logic [6:0]  idx_reg, idx_next;   // byte index within command
    logic        rdv_reg, rdv_next;   // ram read data valid for idx_reg
    logic        ov_reg, ov_next;
    logic [7:0]  ob_reg, ob_next;
    logic        orl_reg, orl_next, osl_reg, osl_next;
    logic [2:0]  ulen;
    logic [7:0]  ubyte;
    logic [31:0] v;
    logic        have, last, out_free;
    logic [7:0]  byte_sel;
    logic [2:0]  k;

    assign v = c_reg.value;
    always_comb begin
        if (v <= 32'h7F) ulen = 3'd1;
        else if (v <= 32'h7FF) ulen = 3'd2;
        else if (v <= 32'hFFFF) ulen = 3'd3;
        else if (v <= 32'h1FFFFF) ulen = 3'd4;
        else if (v <= 32'h3FFFFFF) ulen = 3'd5;
        else ulen = 3'd6;
        k = 3'(ulen - 3'd1 - idx_reg[2:0]);
        ubyte = 8'h80 | 8'(6'((v >> (6 * k))));
        if (idx_reg == 7'd0) begin
            unique case (ulen)
                3'd1: ubyte = v[7:0];
                3'd2: ubyte = 8'hC0 | 8'(v[10:6]);
                3'd3: ubyte = 8'hE0 | 8'(v[15:12]);
                3'd4: ubyte = 8'hF0 | 8'(v[20:18]);
                3'd5: ubyte = 8'hF8 | 8'(v[25:24]);
                default: ubyte = 8'hFC | 8'(v[30]);
            endcase
        end
    end

    assign out_free = !ov_reg || m_ready;
    assign cmd_ready = !busy_reg;

    always_comb begin
        have = 1'b0; last = 1'b0; byte_sel = c_reg.data;
        unique case (c_reg.cmd)
            CMD_UTF8: begin
                have = 1'b1; byte_sel = ubyte;
                last = idx_reg == 7'(ulen - 3'd1);
            end
            CMD_FLUSH: begin
                if (idx_reg < c_reg.count) begin
                    have = rdv_reg; byte_sel = rd_data;
                end else begin
                    have = 1'b1; last = 1'b1;
                end
            end
            default: begin
                have = 1'b1; last = 1'b1;
            end
        endcase
    end

    always_comb begin
        busy_next = busy_reg; c_next = c_reg; idx_next = idx_reg;
        rdv_next = 1'b0;
        rd_addr = idx_reg[AW-1:0];
        ov_next = ov_reg && !m_ready;
        ob_next = ob_reg; orl_next = orl_reg; osl_next = osl_reg;
        if (busy_reg) begin
            rdv_next = 1'b1;
            if (have && out_free) begin
                ov_next = 1'b1; ob_next = byte_sel;
                orl_next = last; osl_next = last && c_reg.eos;
                idx_next = idx_reg + 7'd1;
                rd_addr = AW'(idx_reg + 7'd1);
                if (last) busy_next = 1'b0;
            end
        end else if (cmd_valid) begin
            busy_next = 1'b1; c_next = cmd; idx_next = '0;
            rd_addr = '0;
            rdv_next = 1'b1;
        end
    end

    assign m_valid = ov_reg;
    assign m_out_byte = ob_reg;
    assign m_run_last = orl_reg;
    assign m_string_last = osl_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0; ov_reg <= 1'b0; rdv_reg <= 1'b0; idx_reg <= '0;
        end else begin
            busy_reg <= busy_next; ov_reg <= ov_next; rdv_reg <= rdv_next;
            idx_reg <= idx_next;
        end
        c_reg <= c_next; ob_reg <= ob_next; orl_reg <= orl_next;
        osl_reg <= osl_next;
    end

`include "assert_macros.svh"
    `ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid)
    `ASSERT_IMPLIES(a_sl_rl, aclk, aresetn, m_valid && m_string_last, m_run_last)
    `ASSERT_NEXT(a_take_busy, aclk, aresetn, cmd_valid && cmd_ready, busy_reg)
endmodule
